// ===== rtl/ipv4ts_pkg.sv =====
// Shared types and constants for the IPv4 trie set lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ipv4ts_pkg;

	localparam int OCTET_W = 8;

	localparam logic       OP_INSERT   = 1'b0;
	localparam logic       OP_SEARCH   = 1'b1;
	localparam logic       STATUS_OK   = 1'b0;
	localparam logic       STATUS_FULL = 1'b1;
	localparam logic [1:0] LAST_LEVEL  = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_EMIT  = 5'b10000
	} ipv4ts_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;     // zero one store entry of the clearing pass
		logic load;    // capture the input item
		logic rd;      // read the entry of the current level
		logic alloc;   // link a fresh node and descend into it
		logic follow;  // descend into the child just read
		logic mark;    // set the leaf mark and count the insert
		logic hit;     // flag a search hit
		logic fail;    // flag a full pool
		logic emit;    // load the result register
	} ipv4ts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic op_search;
		logic last_level;
		logic child_zero;
		logic pool_full;
		logic total_zero;
		logic out_free;
	} ipv4ts_sts_t;

endpackage

// ===== rtl/ipv4ts_dp.sv =====
// Datapath of the IPv4 trie set lookup: node store, walk registers, counters
// and result register. Depends on ipv4ts_pkg; driven by ipv4ts_ctrl.
`timescale 1ns / 1ps

module ipv4ts_dp import ipv4ts_pkg::*; #(
	parameter int NODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ipv4ts_cmd_t cmd,
	output ipv4ts_sts_t sts,
	input  logic        operation,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        status,
	output logic [8:0]  nodes_used,
	output logic [31:0] addresses_inserted
);

	localparam int          EW    = $clog2(NODE_COUNT);
	localparam int          AW    = EW + OCTET_W;
	localparam int          FW    = $clog2(NODE_COUNT + 1);
	localparam int unsigned DEPTH = NODE_COUNT * (2 ** OCTET_W);

	logic [EW-1:0]      mem [DEPTH];
	logic [EW-1:0]      rdata_q;
	logic [AW-1:0]      clr_q;
	logic [EW-1:0]      node_q;
	logic [1:0]         level_q;
	logic               op_q;
	logic [31:0]        addr_q;
	logic [FW-1:0]      fill_q;
	logic [31:0]        total_q;
	logic               found_q;
	logic               status_q;
	logic               out_valid_q;

	logic [OCTET_W-1:0] octet;
	logic [AW-1:0]      maddr;
	logic [EW-1:0]      wdata;
	logic               we;

	assign octet = addr_q[{level_q, 3'b000} +: OCTET_W];
	assign maddr = cmd.clr ? clr_q : {node_q, octet};
	assign we    = cmd.clr | cmd.alloc | cmd.mark;

	always_comb begin
		wdata = '0;
		if (cmd.alloc) begin
			wdata = EW'(fill_q);
		end else if (cmd.mark) begin
			wdata = EW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[maddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[maddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			fill_q      <= FW'(1);
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.alloc) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.mark && total_q != 32'hffff_ffff) begin
				total_q <= total_q + 32'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			addr_q   <= address;
			node_q   <= '0;
			level_q  <= '0;
			found_q  <= 1'b0;
			status_q <= STATUS_OK;
		end
		if (cmd.alloc) begin
			node_q  <= EW'(fill_q);
			level_q <= level_q + 2'd1;
		end
		if (cmd.follow) begin
			node_q  <= rdata_q;
			level_q <= level_q + 2'd1;
		end
		if (cmd.hit) begin
			found_q <= 1'b1;
		end
		if (cmd.fail) begin
			status_q <= STATUS_FULL;
		end
		if (cmd.emit) begin
			found              <= found_q;
			status             <= status_q;
			nodes_used         <= 9'(fill_q);
			addresses_inserted <= total_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.clr_last   = (clr_q == AW'(DEPTH - 1));
	assign sts.op_search  = (op_q == OP_SEARCH);
	assign sts.last_level = (level_q == LAST_LEVEL);
	assign sts.child_zero = (rdata_q == '0);
	assign sts.pool_full  = (fill_q == FW'(NODE_COUNT));
	assign sts.total_zero = (total_q == '0);
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

// ===== rtl/ipv4ts_ctrl.sv =====
// Controller of the IPv4 trie set lookup: sequences the clearing pass and the
// level-by-level walk. Depends on ipv4ts_pkg; commands ipv4ts_dp.
`timescale 1ns / 1ps

module ipv4ts_ctrl import ipv4ts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  ipv4ts_sts_t sts,
	output ipv4ts_cmd_t cmd
);

	ipv4ts_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				if (!sts.op_search && sts.last_level) begin
					// insert needs no read at the last level: set the mark
					cmd.mark = 1'b1;
					state_d  = ST_EMIT;
				end else if (sts.op_search && sts.total_zero) begin
					state_d = ST_EMIT;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.last_level) begin
					cmd.hit = !sts.child_zero;
					state_d = ST_EMIT;
				end else if (!sts.child_zero) begin
					cmd.follow = 1'b1;
					state_d    = ST_READ;
				end else if (sts.op_search) begin
					state_d = ST_EMIT;
				end else if (sts.pool_full) begin
					cmd.fail = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.alloc = 1'b1;
					state_d   = ST_READ;
				end
			end
			ST_EMIT: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/ipv4_trie_set_lookup_top.sv =====
// IPv4 address set held as a four-level 256-way trie in a node pool: insert
// and search items give one result item each. Depends on ipv4ts_pkg,
// ipv4ts_ctrl and ipv4ts_dp.
`timescale 1ns / 1ps

// After reset the block clears its node store, one entry a cycle, over all
// NODE_COUNT * 256 entries, and accepts no item during that pass. An item then
// walks the trie one octet level at a time over the single-ported node store,
// with a read state and an evaluate state per level; an insert sets its leaf
// mark at the last level without a read, and a search ends early on a miss.
// The next item is accepted as soon as the result is loaded into the output
// register, even while that result waits on out_stall.
module ipv4_trie_set_lookup_top import ipv4ts_pkg::*; #(
	parameter int NODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        status,
	output logic [8:0]  nodes_used,
	output logic [31:0] addresses_inserted
);

	ipv4ts_cmd_t cmd;
	ipv4ts_sts_t sts;

	ipv4ts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipv4ts_dp #(
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.operation          (operation),
		.address            (address),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.found              (found),
		.status             (status),
		.nodes_used         (nodes_used),
		.addresses_inserted (addresses_inserted)
	);

endmodule

// ===== test/ipv4ts_lookup_checker.sv =====
// Lookup checker for the IPv4 trie set block: watches both channels, predicts
// each result item from its own copy of the trie and compares it field by field.
// Depends on ipv4ts_pkg.
`timescale 1ns / 1ps

module ipv4ts_lookup_checker import ipv4ts_pkg::*; #(
	parameter int NODE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        found,
	input  logic        status,
	input  logic [8:0]  nodes_used,
	input  logic [31:0] addresses_inserted,
	output int          mismatches,
	output int          pending
);

	localparam int FANOUT = 256;

	typedef struct packed {
		logic        found;
		logic        status;
		logic [8:0]  nodes_used;
		logic [31:0] addresses_inserted;
	} lookup_result_t;

	// level one to three entries hold a child node number, level four a leaf mark
	logic [15:0]    trie_nodes [NODE_COUNT * FANOUT];
	int unsigned    nodes_taken;
	logic [31:0]    inserts_done;
	lookup_result_t lookup_results_q [$];

	function automatic lookup_result_t lookup_step(input logic op, input logic [31:0] addr);
		lookup_result_t r;
		int unsigned    node;
		int unsigned    child;
		int unsigned    slot;
		int unsigned    lvl;
		int unsigned    k;
		logic           ran_out;
		logic           present;
		r = '0;
		node = 0;
		ran_out = 1'b0;
		if (op == OP_INSERT) begin
			for (lvl = 0; lvl < LAST_LEVEL && !ran_out; lvl++) begin
				slot = node * FANOUT + addr[lvl * OCTET_W +: OCTET_W];
				child = 32'(trie_nodes[slot]);
				if (child == 0 || child >= NODE_COUNT) begin
					if (nodes_taken >= NODE_COUNT) begin
						ran_out = 1'b1;
					end else begin
						child = nodes_taken;
						for (k = 0; k < FANOUT; k++)
							trie_nodes[child * FANOUT + k] = '0;
						trie_nodes[slot] = child[15:0];
						nodes_taken++;
					end
				end
				node = child;
			end
			// a full pool keeps the nodes already taken but sets no leaf mark
			if (!ran_out) begin
				trie_nodes[node * FANOUT + addr[LAST_LEVEL * OCTET_W +: OCTET_W]] = 16'd1;
				if (inserts_done != 32'hffff_ffff)
					inserts_done++;
			end
			r.status = ran_out ? STATUS_FULL : STATUS_OK;
		end else if (inserts_done != 0) begin
			present = 1'b1;
			for (lvl = 0; lvl < LAST_LEVEL && present; lvl++) begin
				child = 32'(trie_nodes[node * FANOUT + addr[lvl * OCTET_W +: OCTET_W]]);
				if (child == 0 || child >= NODE_COUNT)
					present = 1'b0;
				else
					node = child;
			end
			if (present && trie_nodes[node * FANOUT + addr[LAST_LEVEL * OCTET_W +: OCTET_W]] == 0)
				present = 1'b0;
			r.found = present;
		end
		r.nodes_used = nodes_taken[8:0];
		r.addresses_inserted = inserts_done;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			foreach (trie_nodes[i])
				trie_nodes[i] = '0;
			nodes_taken = 1;
			inserts_done = '0;
			lookup_results_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookup_results_q.size() == 0) begin
					$error("result item with no lookup pending");
					mismatches++;
				end else begin
					want = lookup_results_q.pop_front();
					check_field("found", 32'(want.found), 32'(found));
					check_field("status", 32'(want.status), 32'(status));
					check_field("nodes_used", 32'(want.nodes_used), 32'(nodes_used));
					check_field("addresses_inserted", want.addresses_inserted,
						addresses_inserted);
				end
			end
			if (in_valid && !in_stall)
				lookup_results_q.push_back(lookup_step(operation, address));
			pending <= lookup_results_q.size();
		end
	end

endmodule

// ===== test/tb_ipv4_trie_set_lookup_top.sv =====
// Testbench top for ipv4_trie_set_lookup_top: drives directed and random
// insert and search items, stalls the result side and gives the verdict.
// Depends on ipv4ts_pkg, ipv4_trie_set_lookup_top and ipv4ts_lookup_checker.
`timescale 1ns / 1ps

module tb_ipv4_trie_set_lookup_top import ipv4ts_pkg::*;;

	localparam int NODES        = 256;
	localparam int RANDOM_ITEMS = 1530;
	localparam int WIDE_FROM    = 900;
	localparam int CALM_FROM    = 1250;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;
	// the clearing pass alone runs over NODES * 256 store entries without a handshake
	localparam int STALL_LIMIT  = 300000;
	localparam int DIRECTED     = 18;

	bit          clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic        status;
	logic [8:0]  nodes_used;
	logic [31:0] addresses_inserted;

	int          mismatches;
	int          pending;
	int          idle_pct;
	bit          hold_request;
	int          quiet_cycles;

	ipv4_trie_set_lookup_top #(.NODE_COUNT(NODES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.status(status),
		.nodes_used(nodes_used),
		.addresses_inserted(addresses_inserted)
	);

	ipv4ts_lookup_checker #(.NODE_COUNT(NODES)) lookup_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.status(status),
		.nodes_used(nodes_used),
		.addresses_inserted(addresses_inserted),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("ipv4_trie_set_lookup_top regression: fail");
			$finish;
		end
	end

	// result side: short random stalls, and one long hold-off to fill the block
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input logic [31:0] addr);
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin
		logic        dir_op   [DIRECTED];
		logic [31:0] dir_addr [DIRECTED];
		logic [7:0]  octet_choice [3][4];
		logic [31:0] known_addrs [$];
		logic [31:0] addr;
		logic        op;
		int          roll;
		int          n;
		int          k;
		quiet_cycles = 0;
		idle_pct = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		operation <= OP_INSERT;
		address <= '0;

		// empty set, hits, misses at the first and third level, leaf missing, duplicate insert
		dir_op = '{OP_SEARCH, OP_SEARCH, OP_INSERT, OP_SEARCH, OP_SEARCH, OP_SEARCH,
			OP_INSERT, OP_SEARCH, OP_INSERT, OP_SEARCH, OP_INSERT, OP_INSERT,
			OP_SEARCH, OP_SEARCH, OP_SEARCH, OP_INSERT, OP_SEARCH, OP_SEARCH};
		dir_addr = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000,
			32'h0100_0000, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff,
			32'h0000_0000, 32'h0000_0000, 32'h55aa_55aa, 32'haa55_aa55,
			32'h55aa_55aa, 32'haa55_aa55, 32'h55ab_55aa, 32'h0000_ff00,
			32'h0000_ff00, 32'h00ff_0000};

		for (k = 0; k < 3; k++) begin
			octet_choice[k][0] = 8'h00;
			octet_choice[k][1] = 8'hff;
			octet_choice[k][2] = 8'($urandom);
			octet_choice[k][3] = 8'($urandom);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < DIRECTED; n++)
			send_item(dir_op[n], dir_addr[n]);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 35;
				endcase
				if (n >= CALM_FROM)
					idle_pct = 0;
			end
			if (n == HOLD_AT)
				hold_request = 1'b1;
			op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH;
			roll = $urandom_range(0, 99);
			if (op == OP_SEARCH && roll < 55 && known_addrs.size() > 0) begin
				addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
			end else if (roll >= 85 || (n >= WIDE_FROM && op == OP_INSERT && roll < 40)) begin
				// fully random paths; in the later part these exhaust the pool
				addr = $urandom;
			end else begin
				for (k = 0; k < 3; k++)
					addr[k * OCTET_W +: OCTET_W] = octet_choice[k][$urandom_range(0, 3)];
				addr[31:24] = 8'($urandom);
			end
			if (op == OP_INSERT)
				known_addrs.push_back(addr);
			send_item(op, addr);
		end
		in_valid <= 1'b0;

		// let the count of outstanding lookups catch up with the last item
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ipv4_trie_set_lookup_top regression: pass");
		else
			$display("ipv4_trie_set_lookup_top regression: fail");
		$finish;
	end

endmodule
